// File: hdl/ks_pkg.sv
// ----------------------------------------------------------------------------
// ks_pkg: shared types and constants for the k-smallest selector
// Payload structs, controller state, command and status bundles.
// ----------------------------------------------------------------------------
package ks_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KCNT_W  = 5;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register indexes
  localparam logic REG_K_COUNT = 1'b0;

  localparam logic [KCNT_W-1:0] K_COUNT_RST = 5'd16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      set_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kept_value;
    logic                      last_kept;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_TAKE,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;       // insert the incoming value into the chain
    logic shift_out;  // head has been delivered, shift chain up
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;       // exactly one entry left in the chain
  } dp_status_t;

endpackage

// File: hdl/ks_cfg.sv
// ----------------------------------------------------------------------------
// ks_cfg: APB-style register file
// Holds k_count; writes complete in the access phase, pready always high.
// ----------------------------------------------------------------------------
module ks_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ks_pkg::APB_AW-1:0]  paddr,
  input  logic [ks_pkg::APB_DW-1:0]  pwdata,
  output logic [ks_pkg::APB_DW-1:0]  prdata,
  output logic                       pready,
  output logic [ks_pkg::KCNT_W-1:0]  k_count_o
);

  logic [ks_pkg::KCNT_W-1:0] k_count_q, k_count_d;
  logic                      sel_k;

  // word index sits above the byte lane bits
  assign sel_k  = (paddr[2] == ks_pkg::REG_K_COUNT);
  assign pready = 1'b1;

  // write decode
  always_comb begin
    k_count_d = k_count_q;
    if (psel && penable && pwrite && sel_k) begin
      k_count_d = pwdata[ks_pkg::KCNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_count_q <= ks_pkg::K_COUNT_RST;
    end else begin
      k_count_q <= k_count_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_k) begin
      prdata = {{(ks_pkg::APB_DW-ks_pkg::KCNT_W){1'b0}}, k_count_q};
    end
  end

  assign k_count_o = k_count_q;

endmodule

// File: hdl/ks_ctrl.sv
// ----------------------------------------------------------------------------
// ks_ctrl: selector controller
// Collects values until the end of a set, then drains the sorted chain.
// ----------------------------------------------------------------------------
module ks_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_set_end_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ks_pkg::dp_status_t  status_i,
  output ks_pkg::ctrl_cmd_t   cmd_o
);

  ks_pkg::ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ks_pkg::ST_TAKE: begin
        if (in_valid_i && in_set_end_i) begin
          state_d = ks_pkg::ST_EMIT;
        end
      end
      ks_pkg::ST_EMIT: begin
        if (out_ready_i && status_i.last) begin
          state_d = ks_pkg::ST_TAKE;
        end
      end
      default: state_d = ks_pkg::ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ks_pkg::ST_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.shift_out = 1'b0;
    unique case (state_q)
      ks_pkg::ST_TAKE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ks_pkg::ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.shift_out = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/ks_datapath.sv
// ----------------------------------------------------------------------------
// ks_datapath: sorted register chain
// Entries kept largest first; every entry compares against the new value in
// parallel, so an insert or a replace of the head completes in a single chain update.
// ----------------------------------------------------------------------------
module ks_datapath #(
  parameter int unsigned K_MAX = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ks_pkg::ctrl_cmd_t                   cmd_i,
  input  logic signed [ks_pkg::VALUE_W-1:0]   value_i,
  input  logic [ks_pkg::KCNT_W-1:0]           k_count_i,
  output ks_pkg::dp_status_t                  status_o,
  output logic signed [ks_pkg::VALUE_W-1:0]   head_o
);

  localparam int unsigned CNT_W = $clog2(K_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > ks_pkg::KCNT_W) ? CNT_W : ks_pkg::KCNT_W;

  logic signed [ks_pkg::VALUE_W-1:0] store_q [K_MAX];
  logic signed [ks_pkg::VALUE_W-1:0] store_d [K_MAX];
  logic signed [ks_pkg::VALUE_W-1:0] prv_val [K_MAX];
  logic signed [ks_pkg::VALUE_W-1:0] nxt_val [K_MAX];
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [K_MAX-1:0]                  ent_vld, ge_v, gt_v, prv_ge, nxt_gt;
  logic [ks_pkg::KCNT_W-1:0]         k_lim;
  logic                              do_append, do_replace;

  // neighbour taps and per-entry compares
  for (genvar i = 0; i < K_MAX; i++) begin : g_ent
    assign ent_vld[i] = (CNT_W'(i) < count_q);
    assign ge_v[i]    = ent_vld[i] && (store_q[i] >= value_i);
    assign gt_v[i]    = ent_vld[i] && (store_q[i] > value_i);
    if (i == 0) begin : g_first
      assign prv_val[i] = store_q[i];
      assign prv_ge[i]  = 1'b1;
    end else begin : g_mid
      assign prv_val[i] = store_q[i-1];
      assign prv_ge[i]  = ge_v[i-1];
    end
    if (i == K_MAX - 1) begin : g_last
      assign nxt_val[i] = store_q[i];
      assign nxt_gt[i]  = 1'b0;
    end else begin : g_body
      assign nxt_val[i] = store_q[i+1];
      assign nxt_gt[i]  = gt_v[i+1];
    end
  end

  // a k of zero behaves as one; the store size caps the rest
  assign k_lim      = (k_count_i == '0) ? ks_pkg::KCNT_W'(1) : k_count_i;
  assign do_append  = (CMP_W'(count_q) < CMP_W'(k_lim)) && (count_q < CNT_W'(K_MAX));
  assign do_replace = !do_append && (count_q != '0) && (value_i < store_q[0]);

  // chain update
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < K_MAX; i++) begin
      store_d[i] = store_q[i];
    end
    priority if (cmd_i.shift_out) begin
      for (int i = 0; i < K_MAX; i++) begin
        store_d[i] = nxt_val[i];
      end
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.take && do_append) begin
      // open a slot behind all entries not below the new value
      for (int i = 0; i < K_MAX; i++) begin
        if (ge_v[i]) begin
          store_d[i] = store_q[i];
        end else if (prv_ge[i]) begin
          store_d[i] = value_i;
        end else begin
          store_d[i] = prv_val[i];
        end
      end
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.take && do_replace) begin
      // drop the head, close up entries above the new value; the new value
      // lands on the last entry still above it
      for (int i = 0; i < K_MAX; i++) begin
        if (nxt_gt[i]) begin
          store_d[i] = nxt_val[i];
        end else if (gt_v[i]) begin
          store_d[i] = value_i;
        end else begin
          store_d[i] = store_q[i];
        end
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < K_MAX; i++) begin
      store_q[i] <= store_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o.last = (count_q == CNT_W'(1));
  assign head_o        = store_q[0];

endmodule

// File: hdl/k_smallest_selector.sv
// ----------------------------------------------------------------------------
// k_smallest_selector: keeps the k smallest signed values of each set
// Controller plus sorted register chain datapath, APB-style k_count register.
// ----------------------------------------------------------------------------
// While a set is collected the block takes one value per cycle: every entry of
// the sorted register chain compares with the incoming value at once, so an
// insert, or a replace of the largest entry, is a single chain update. An item
// marked set_end switches the block to draining: the n kept values (n up to
// k) leave largest first, one per cycle while out_ready_i is high, as the chain
// shifts up, and no input transaction is taken while they drain. The chain
// is empty again after its last value, marked by last_kept, has been taken.
module k_smallest_selector #(
  parameter int unsigned K_MAX = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ks_pkg::APB_AW-1:0]  paddr,
  input  logic [ks_pkg::APB_DW-1:0]  pwdata,
  output logic [ks_pkg::APB_DW-1:0]  prdata,
  output logic                       pready,
  // input values
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ks_pkg::in_item_t           in_data_i,
  // kept values
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ks_pkg::out_item_t          out_data_o
);

  logic [ks_pkg::KCNT_W-1:0]         k_count;
  ks_pkg::ctrl_cmd_t                 cmd;
  ks_pkg::dp_status_t                status;
  logic signed [ks_pkg::VALUE_W-1:0] head;

  ks_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .k_count_o (k_count)
  );

  ks_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_set_end_i (in_data_i.set_end),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ks_datapath #(
    .K_MAX (K_MAX)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (in_data_i.value),
    .k_count_i (k_count),
    .status_o  (status),
    .head_o    (head)
  );

  // head of the chain is the outgoing transaction
  assign out_data_o.kept_value = head;
  assign out_data_o.last_kept  = status.last;

endmodule

// File: tb/sv/k_smallest_selector_tb.sv
// ----------------------------------------------------------------------------
// k_smallest_selector_tb: self-checking bench for the k-smallest selector
// Streams sets of signed values through the valid/ready input and tracks the
// k smallest of each set in a local sorted store. Every emitted value is
// compared with the tracked one, largest first. k_count is changed over the
// APB-style port between sets and in mid-set, and is read back after some of the writes.
// ----------------------------------------------------------------------------
module k_smallest_selector_tb;

  localparam int unsigned VALUE_W = ks_pkg::VALUE_W;
  localparam int unsigned KCNT_W  = ks_pkg::KCNT_W;
  localparam int unsigned APB_AW  = ks_pkg::APB_AW;
  localparam int unsigned APB_DW  = ks_pkg::APB_DW;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned RAND_ITEMS     = 130;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned IDLE_PCT       = 38;

  localparam logic [APB_AW-1:0] K_COUNT_ADDR = APB_AW'(ks_pkg::REG_K_COUNT) << 2;
  localparam logic [APB_AW-1:0] SPARE_ADDR   = APB_AW'(4);

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // value distributions for random sets
  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_EDGE
  } value_mix_e;

  // Tracks the kept values of the current set and the values still due out
  class kept_tracker;
    logic [KCNT_W-1:0]         k_reg;
    logic signed [VALUE_W-1:0] kept [DEPTH];
    int unsigned               kept_n;
    ks_pkg::out_item_t         kept_due[$];
    int unsigned               errors;
    int unsigned               values_in;
    int unsigned               sets_done;
    int unsigned               values_checked;
    int unsigned               reg_writes;

    function new();
      k_reg          = ks_pkg::K_COUNT_RST;
      kept_n         = 0;
      errors         = 0;
      values_in      = 0;
      sets_done      = 0;
      values_checked = 0;
      reg_writes     = 0;
    endfunction

    // k_count of zero keeps one, anything above the depth keeps the depth
    function int unsigned active_k();
      if (k_reg == 0) return 1;
      if (k_reg > DEPTH) return DEPTH;
      return 32'(k_reg);
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      reg_writes++;
      if (addr == K_COUNT_ADDR) k_reg = data[KCNT_W-1:0];
    endfunction

    // store held descending; a full store only admits a strictly smaller value
    function void take_value(logic signed [VALUE_W-1:0] v);
      int unsigned k;
      int unsigned p;
      k = active_k();
      if (kept_n < k && kept_n < DEPTH) begin
        p = kept_n;
        while (p > 0 && kept[p-1] < v) begin
          kept[p] = kept[p-1];
          p--;
        end
        kept[p] = v;
        kept_n++;
      end else if (kept_n > 0 && v < kept[0]) begin
        p = 0;
        while (p + 1 < kept_n && kept[p+1] > v) begin
          kept[p] = kept[p+1];
          p++;
        end
        kept[p] = v;
      end
    endfunction

    function void note_input(ks_pkg::in_item_t it);
      ks_pkg::out_item_t o;
      values_in++;
      take_value(it.value);
      if (it.set_end) begin
        for (int unsigned i = 0; i < kept_n; i++) begin
          o.kept_value = kept[i];
          o.last_kept  = (i + 1 == kept_n);
          kept_due.push_back(o);
        end
        kept_n = 0;
        sets_done++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(ks_pkg::out_item_t got);
      ks_pkg::out_item_t want;
      if (kept_due.size() == 0) begin
        report($sformatf("kept value %0d with none due", $signed(got.kept_value)));
        return;
      end
      want = kept_due.pop_front();
      values_checked++;
      if (got.kept_value !== want.kept_value)
        report($sformatf("kept_value %0d, wanted %0d",
                         $signed(got.kept_value), $signed(want.kept_value)));
      if (got.last_kept !== want.last_kept)
        report($sformatf("last_kept %0b, wanted %0b (value %0d)",
                         got.last_kept, want.last_kept, $signed(want.kept_value)));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  ks_pkg::in_item_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  ks_pkg::out_item_t out_data_o;

  kept_tracker tracker;
  logic        no_idle;
  int unsigned rand_sent;
  int unsigned set_idx;
  int unsigned set_len;
  value_mix_e  mix;

  k_smallest_selector #(
    .K_MAX(DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  // receiver stalls at random unless a no-idle stretch is running
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // transaction monitor: results are checked before the same edge's input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_result(out_data_o);
      if (in_valid_i && in_ready_o) tracker.note_input(in_data_i);
    end
  end

  function automatic logic signed [VALUE_W-1:0] gen_value(value_mix_e m);
    logic signed [VALUE_W-1:0] v;
    v = $urandom();
    case (m)
      MIX_NARROW:  v = $signed($urandom_range(15)) - 8;
      MIX_EXTREME: begin
        case ($urandom_range(5))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 0;
          3: v = -1;
          4: v = VAL_MAX - 1;
          default: v = VAL_MIN + 1;
        endcase
      end
      MIX_EDGE:    if ($urandom_range(1) == 0) v = VAL_MIN + $urandom_range(7);
                   else v = VAL_MAX - $urandom_range(7);
      default:     v = $urandom();
    endcase
    return v;
  endfunction

  // k settings biased toward the extremes; upper data bits are don't-care
  function automatic logic [APB_DW-1:0] pick_k();
    logic [APB_DW-1:0] d;
    d = $urandom();
    case ($urandom_range(7))
      0: d[KCNT_W-1:0] = '0;
      1: d[KCNT_W-1:0] = KCNT_W'(1);
      2: d[KCNT_W-1:0] = KCNT_W'(DEPTH);
      3: d[KCNT_W-1:0] = KCNT_W'(31);
      4: d[KCNT_W-1:0] = KCNT_W'($urandom_range(31, DEPTH + 1));
      default: d[KCNT_W-1:0] = KCNT_W'($urandom_range(DEPTH, 1));
    endcase
    return d;
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_value(logic signed [VALUE_W-1:0] v, logic last);
    ks_pkg::in_item_t it;
    it.value   = v;
    it.set_end = last;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and let every due value drain out
  task automatic wait_idle(int unsigned extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.kept_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(addr, data);
    @(posedge clk_i);
  endtask

  // read k_count back and compare with the tracked setting
  task automatic apb_read_check();
    logic [APB_DW-1:0] want;
    want    = APB_DW'(tracker.k_reg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= K_COUNT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      tracker.report($sformatf("k_count read %0d, wanted %0d", prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    tracker     = new();
    no_idle     = 1'b0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check();

    // set shorter than k, value extremes
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(0, 1'b0);
    send_value(-1, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // k_count of zero keeps one; equal value must not displace
    apb_write(K_COUNT_ADDR, 0);
    apb_read_check();
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(3, 1'b0);
    send_value(7, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // k of three, then k lowered in mid-set: kept entries stay kept
    apb_write(K_COUNT_ADDR, 3);
    send_value(10, 1'b0);
    send_value(20, 1'b0);
    send_value(30, 1'b0);
    send_value(30, 1'b0);
    send_value(25, 1'b0);
    wait_idle(SETTLE_CYCLES);
    apb_write(K_COUNT_ADDR, 1);
    send_value(15, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // write to an unmapped register is ignored; k above the depth
    apb_write(SPARE_ADDR, 2);
    apb_read_check();
    apb_write(K_COUNT_ADDR, 32'hFFFF_FFFF);
    apb_read_check();
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // k of two, new minimum arrives with the set end
    apb_write(K_COUNT_ADDR, 2);
    send_value(-100, 1'b0);
    send_value(100, 1'b0);
    send_value(-50, 1'b0);
    send_value(VAL_MIN, 1'b1);

    // random sets, with a run of sets free of idle cycles
    rand_sent = 0;
    set_idx   = 0;
    while (rand_sent < RAND_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        wait_idle(SETTLE_CYCLES);
        apb_write(K_COUNT_ADDR, pick_k());
        apb_read_check();
      end
      no_idle = (set_idx >= 4 && set_idx < 8);
      set_len = ($urandom_range(5) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      mix     = value_mix_e'($urandom_range(3));
      for (int unsigned i = 0; i < set_len; i++) begin
        if (i == set_len / 2 && set_len > 2 && $urandom_range(5) == 0) begin
          wait_idle(SETTLE_CYCLES);
          apb_write(K_COUNT_ADDR, pick_k());
        end
        send_value(gen_value(mix), i == set_len - 1);
      end
      rand_sent += set_len;
      set_idx++;
    end
    no_idle = 1'b0;

    wait_idle(TAIL_CYCLES);
    $display("Covered %0d values in %0d sets, %0d kept values checked, %0d register writes",
             tracker.values_in, tracker.sets_done, tracker.values_checked,
             tracker.reg_writes);
    $display("k from zero to above the depth, equal values, mid-set k changes");
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ks_pkg.sv
hdl/ks_cfg.sv
hdl/ks_ctrl.sv
hdl/ks_datapath.sv
hdl/k_smallest_selector.sv
tb/sv/k_smallest_selector_tb.sv
